/* sv/wbpm_pkg.sv */
// Shared types and constants for the wildcard byte pattern matcher.
// Used by the config register block, the match core and the top level.
package wbpm_pkg;

  localparam int ADDR_W     = 48;
  localparam int BYTE_W     = 8;
  localparam int PB_MAX     = 8;   // widest pattern the derived config can hold
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 6;
  localparam int NUM_W      = 5;
  localparam int DEV_W      = 16;
  localparam int MASK_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN     = 3'd0,
    REG_WILDCARD    = 3'd1,
    REG_LENGTH      = 3'd2,
    REG_DEVIATION   = 3'd3,
    REG_MAX_MATCHES = 3'd4,
    REG_MODULE_BASE = 3'd5,
    REG_RELATIVE    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              region_start;
    logic              scan_start;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] match_address;
    logic [NUM_W-1:0]  match_number;
    logic              limit_reached;
  } out_item_t;

  // Pattern settings pre-aligned to window positions (position 0 = oldest byte)
  typedef struct packed {
    logic [PB_MAX-1:0][BYTE_W-1:0] want;
    logic [PB_MAX-1:0]             care;
    logic [LEN_W-1:0]              len;
    logic [CNT_W-1:0]              limit;
    logic [ADDR_W-1:0]             offset;
  } match_cfg_t;

endpackage

/* sv/wbpm_cfg_regs.sv */
// Configuration registers of the pattern matcher and the derived match settings.
// Depends on wbpm_pkg.
module wbpm_cfg_regs #(
  parameter int PATTERN_BYTES   = 8,
  parameter int MAX_MATCH_COUNT = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wbpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output wbpm_pkg::match_cfg_t                mcfg
);
  import wbpm_pkg::*;

  localparam logic [LEN_W-1:0] PB_LEN  = LEN_W'(PATTERN_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MATCH_COUNT);

  logic [CFG_DATA_W-1:0] pattern_r, pattern_nxt;
  logic [MASK_W-1:0]     wild_r, wild_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [DEV_W-1:0]      dev_r, dev_nxt;
  logic [CNT_W-1:0]      maxm_r, maxm_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic                  rel_r, rel_nxt;
  match_cfg_t            mcfg_r, mcfg_nxt;

  // Align pattern to the window, clamp length and limit, fold the address terms
  function automatic match_cfg_t derive(
    input logic [CFG_DATA_W-1:0] pat,
    input logic [MASK_W-1:0]     wild,
    input logic [LEN_W-1:0]      len,
    input logic [DEV_W-1:0]      dev,
    input logic [CNT_W-1:0]      maxm,
    input logic [ADDR_W-1:0]     base,
    input logic                  rel
  );
    match_cfg_t       d;
    logic [LEN_W-1:0] l;
    int               k;
    logic [2:0]       kk;
    l = len;
    if (l == '0) l = LEN_W'(1);
    else if (l > PB_LEN) l = PB_LEN;
    d = '0;
    d.len = l;
    for (int j = 0; j < PB_MAX; j++) begin
      k  = j - PATTERN_BYTES + int'(l);
      kk = 3'(k);
      if (j < PATTERN_BYTES && k >= 0) begin
        d.want[j] = pat[kk*BYTE_W +: BYTE_W];
        d.care[j] = ~wild[kk];
      end
    end
    d.limit = maxm;
    if (maxm == '0) d.limit = CNT_W'(1);
    else if (maxm > MAX_CNT) d.limit = MAX_CNT;
    // start = newest address - (len - 1); deviation sign extended
    d.offset = {{(ADDR_W-DEV_W){dev[DEV_W-1]}}, dev} - ADDR_W'(l - LEN_W'(1))
             - (rel ? base : '0);
    return d;
  endfunction

  // Register write decode
  always_comb begin
    pattern_nxt = pattern_r;
    wild_nxt    = wild_r;
    len_nxt     = len_r;
    dev_nxt     = dev_r;
    maxm_nxt    = maxm_r;
    base_nxt    = base_r;
    rel_nxt     = rel_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN:     pattern_nxt = cfg_wdata;
        REG_WILDCARD:    wild_nxt    = cfg_wdata[MASK_W-1:0];
        REG_LENGTH:      len_nxt     = cfg_wdata[LEN_W-1:0];
        REG_DEVIATION:   dev_nxt     = cfg_wdata[DEV_W-1:0];
        REG_MAX_MATCHES: maxm_nxt    = cfg_wdata[CNT_W-1:0];
        REG_MODULE_BASE: base_nxt    = cfg_wdata[ADDR_W-1:0];
        REG_RELATIVE:    rel_nxt     = cfg_wdata[0];
        default: ;
      endcase
    end
    mcfg_nxt = derive(pattern_nxt, wild_nxt, len_nxt, dev_nxt, maxm_nxt, base_nxt, rel_nxt);
  end

  // Raw and derived settings update on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      wild_r    <= '0;
      len_r     <= LEN_W'(8);
      dev_r     <= '0;
      maxm_r    <= CNT_W'(32);
      base_r    <= '0;
      rel_r     <= 1'b0;
      mcfg_r    <= derive('0, '0, LEN_W'(8), '0, CNT_W'(32), '0, 1'b0);
    end else begin
      pattern_r <= pattern_nxt;
      wild_r    <= wild_nxt;
      len_r     <= len_nxt;
      dev_r     <= dev_nxt;
      maxm_r    <= maxm_nxt;
      base_r    <= base_nxt;
      rel_r     <= rel_nxt;
      mcfg_r    <= mcfg_nxt;
    end
  end

  assign mcfg = mcfg_r;

endmodule

/* sv/wbpm_match_core.sv */
// Byte window, fill and scan state, window compare and match address add.
// Depends on wbpm_pkg; settings come from wbpm_cfg_regs.
module wbpm_match_core #(
  parameter int PATTERN_BYTES = 8,
  parameter int ADDRESS_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  wbpm_pkg::in_item_t   item,
  input  wbpm_pkg::match_cfg_t mcfg,
  output logic                 hit,
  output wbpm_pkg::out_item_t  res
);
  import wbpm_pkg::*;

  localparam logic [LEN_W-1:0]  PB_LEN    = LEN_W'(PATTERN_BYTES);
  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                            ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic [PATTERN_BYTES-1:0][BYTE_W-1:0] window_r, win_base, win_new;
  logic [LEN_W-1:0] fill_r, fill_base, fill_new;
  logic [CNT_W-1:0] count_r, count_eff, count_inc;
  logic             stopped_r, stop_eff;
  logic             eq, limit_hit;

  always_comb begin
    // Scan start clears count and stop; a stopped scan ignores the byte
    count_eff = item.scan_start ? '0 : count_r;
    stop_eff  = item.scan_start ? 1'b0 : stopped_r;
    // Region start empties the window before the byte goes in
    win_base  = item.region_start ? '0 : window_r;
    fill_base = item.region_start ? '0 : fill_r;
    win_new   = win_base;
    for (int j = 0; j < PATTERN_BYTES - 1; j++) begin
      win_new[j] = win_base[j+1];
    end
    win_new[PATTERN_BYTES-1] = item.data_byte;
    fill_new = (fill_base < PB_LEN) ? fill_base + LEN_W'(1) : fill_base;
    // Compare every window position against the aligned pattern
    eq = 1'b1;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (mcfg.care[j] && win_new[j] != mcfg.want[j]) eq = 1'b0;
    end
    hit       = !stop_eff && (fill_new >= mcfg.len) && eq;
    count_inc = count_eff + CNT_W'(1);
    limit_hit = count_inc >= mcfg.limit;
    res.match_address = (item.byte_address + mcfg.offset) & ADDR_MASK;
    res.match_number  = count_eff[NUM_W-1:0];
    res.limit_reached = limit_hit;
  end

  // Window contents; fill gates every read, so no reset
  always_ff @(posedge clk) begin
    if (adv && !stop_eff) window_r <= win_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (adv) begin
      if (!stop_eff) fill_r <= fill_new;
      count_r   <= hit ? count_inc : count_eff;
      stopped_r <= stop_eff || (hit && limit_hit);
    end
  end

`ifndef SYNTH
  a_stop_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> count_r != '0)
    else $error("scan stopped with zero match count");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PB_LEN)
    else $error("window fill beyond window size");
  a_limit_stops: assert property (@(posedge clk) disable iff (!rst_n)
    adv && hit && res.limit_reached |=> stopped_r)
    else $error("limit match did not stop the scan");
`endif

endmodule

/* sv/wildcard_byte_pattern_matcher.sv */
// Top level of the wildcard byte pattern matcher: input stage, output register.
// Depends on wbpm_pkg, wbpm_cfg_regs and wbpm_match_core.
//
// Usage:
//  in_*  : one memory byte per word with its address and region/scan start flags.
//  out_* : one word per pattern match: start address (+ deviation, - base in
//          relative mode), match index within the scan, limit flag.
//  cfg_* : register writes, taken in the cycle cfg_we is high; write only
//          while no word is in flight.
// Timing: the input register takes the word at the accepting edge and the
//  result register loads when the input stage advances, which a waiting
//  result that out_ready does not take holds back.
// Throughput: one byte per cycle unless a stall holds the input stage, set by
//  the combinational window compare and address add between the two registers.
// Reset: settings return to their defaults, the window empties, match count
//  and stop flag clear; no clearing pass, the block is ready right away.
// Stall: while a result waits on out_ready the result register holds; the input
//  register still takes one more byte, then in_ready drops until the result is taken.
module wildcard_byte_pattern_matcher #(
  parameter int PATTERN_BYTES   = 8,
  parameter int MAX_MATCH_COUNT = 32,
  parameter int ADDRESS_BITS    = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wbpm_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wbpm_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [wbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wbpm_pkg::*;

  match_cfg_t mcfg;
  in_item_t   s1_item_r;
  logic       s1_v_r, s1_v_nxt;
  logic       s1_adv, in_acc;
  logic       core_hit;
  out_item_t  core_res, out_item_r;
  logic       out_v_r, out_v_nxt;

  wbpm_cfg_regs #(
    .PATTERN_BYTES  (PATTERN_BYTES),
    .MAX_MATCH_COUNT(MAX_MATCH_COUNT)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mcfg     (mcfg)
  );

  wbpm_match_core #(
    .PATTERN_BYTES(PATTERN_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (s1_adv),
    .item (s1_item_r),
    .mcfg (mcfg),
    .hit  (core_hit),
    .res  (core_res)
  );

  // Input stage moves on whenever the result register is free or draining
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) s1_v_nxt = 1'b1;
    else if (s1_adv) s1_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (s1_adv) out_v_nxt = core_hit;
    else if (out_ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= in_item;
    if (s1_adv && core_hit) out_item_r <= core_res;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_adv))
    else $error("result appeared without an input stage advance");
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_item_r))
    else $error("stalled input stage lost or changed its word");
  a_hit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && core_hit |=> out_v_r)
    else $error("match did not reach the result register");
`endif

endmodule
